### rtl/core/cle_pkg.sv
// Console line editor package: event codes, control byte codes and defaults.
// Used by console_line_editor_top; depends on nothing.
package cle_pkg;

	localparam int LINE_MAX_DEF = 128;
	localparam logic [7:0] BUF_SIZE_RST = 8'd128;

	localparam int BYTE_W = 8;
	localparam int IDX_W = 7;
	localparam int CNT_W = 7;

	// Control bytes seen on the console
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_KILL = 8'h15;
	localparam logic [7:0] CH_SPEC_LO = 8'hfe;
	localparam logic [7:0] CH_SPEC_HI = 8'hff;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7f;

	typedef enum logic [0:0] {
		REQ_RX = 1'b0,
		REQ_READ = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		EV_ECHO = 3'd0,
		EV_ERASE = 3'd1,
		EV_DONE = 3'd2,
		EV_SPECIAL = 3'd3,
		EV_READ = 3'd4
	} event_t;

endpackage

### rtl/core/console_line_editor_top.sv
// Console line editor: builds one line from received console bytes in a byte store.
// Each result is registered and valid in the cycle after its request is taken; one
// request per cycle unless a result is stalled. The store is one synchronous memory
// with a single write and a single read per cycle; the fill count lives in a register.
// Reset (arst_n, async) clears the fill count, the output stage and sets buffer_size 128;
// the store itself is not cleared and reads undefined until written.
module console_line_editor_top #(
	parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: buffer_size
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
	input  logic [0:0]  s_tuser,   // [0] req_type
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [14:8] erase_count, [21:15] line_length
	output logic [2:0]  m_tuser    // [2:0] event_res
);
	import cle_pkg::*;

	localparam int DEPTH = (LINE_MAX < 128) ? LINE_MAX : 128;
	localparam int AW = $clog2(DEPTH);
	localparam logic [7:0] DEPTH_B = 8'(DEPTH);

	logic [BYTE_W-1:0] line_mem [DEPTH];

	logic [7:0]       buf_size_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_d;

	logic             valid_s1;
	event_t           ev_s1;
	logic [7:0]       ob_s1;
	logic [CNT_W-1:0] ec_s1;
	logic [CNT_W-1:0] ll_s1;
	logic             rd_ok_s1;
	logic [7:0]       rd_data_s1;

	logic             accept;
	logic [7:0]       rx_byte;
	logic [IDX_W-1:0] read_index;
	req_t             req;

	event_t           ev_d;
	logic [7:0]       ob_d;
	logic [CNT_W-1:0] ec_d;
	logic [CNT_W-1:0] ll_d;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	logic             rd_ok;
	logic [7:0]       lim;
	logic [7:0]       cap;
	logic             printable;

	assign rx_byte = s_tdata[7:0];
	assign read_index = s_tdata[14:8];
	assign req = req_t'(s_tuser[0]);

	assign s_tready = !valid_s1 || m_tready;
	assign accept = s_tvalid && s_tready;

	// kept bytes: min(buffer_size, store depth) - 1, or 0 when that min is 0
	assign lim = (buf_size_q > DEPTH_B) ? DEPTH_B : buf_size_q;
	assign cap = (lim == 8'd0) ? 8'd0 : lim - 8'd1;
	assign printable = (rx_byte >= CH_PRINT_LO) && (rx_byte < CH_DEL);
	assign rd_ok = ({1'b0, read_index} < DEPTH_B);

	always_comb begin
		ev_d = EV_ECHO;
		ob_d = '0;
		ec_d = '0;
		ll_d = '0;
		fill_d = fill_q;
		wr_en = 1'b0;
		wr_addr = fill_q[AW-1:0];
		wr_data = rx_byte;
		if (req == REQ_READ) begin
			ev_d = EV_READ;
		end else if (rx_byte == CH_LF || rx_byte == CH_CR) begin
			ev_d = EV_DONE;
			ll_d = fill_q;
			fill_d = '0;
		end else if (rx_byte == CH_BS) begin
			ev_d = EV_ERASE;
			ec_d = CNT_W'(1);
			if (fill_q != '0) begin
				fill_d = fill_q - CNT_W'(1);
			end
		end else if (rx_byte == CH_KILL) begin
			ev_d = EV_ERASE;
			ec_d = fill_q;
			fill_d = '0;
		end else if (rx_byte == CH_SPEC_LO || rx_byte == CH_SPEC_HI) begin
			ev_d = EV_SPECIAL;
			ob_d = rx_byte;
			ll_d = CNT_W'(1);
			fill_d = '0;
			wr_en = 1'b1;
			wr_addr = '0;
		end else begin
			ev_d = EV_ECHO;
			ob_d = rx_byte;
			if (printable && ({1'b0, fill_q} < cap)) begin
				wr_en = 1'b1;
				fill_d = fill_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q <= BUF_SIZE_RST;
		end else if (cfg_we) begin
			buf_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_d;
				valid_s1 <= 1'b1;
			end else if (m_tready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= ev_d;
			ob_s1 <= ob_d;
			ec_s1 <= ec_d;
			ll_s1 <= ll_d;
			rd_ok_s1 <= rd_ok;
		end
	end

	// store: one write, one registered read per cycle; a write lands at the edge that takes its
	// request, before any later request can read it, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
		if (accept && req == REQ_READ) begin
			rd_data_s1 <= line_mem[read_index[AW-1:0]];
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tuser = ev_s1;
	assign m_tdata = {2'b00, ll_s1, ec_s1,
		(ev_s1 == EV_READ) ? (rd_ok_s1 ? rd_data_s1 : 8'h00) : ob_s1};

	// fill count never points past the last store entry
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, fill_q} < DEPTH_B + 8'd0 || DEPTH == 128)
		else $error("fill count beyond store");

	// a line kill empties the line and reports it as an erase
	a_kill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_RX && rx_byte == CH_KILL |=>
		fill_q == '0 && m_tvalid && m_tuser == EV_ERASE)
		else $error("kill did not clear line");

	// a read request leaves the line untouched
	a_read_no_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_READ |=> fill_q == $past(fill_q))
		else $error("read changed fill count");

	// requests are held off only by a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("ready dropped without stall");

endmodule

### sim/console_line_editor_top_tb.sv
// Testbench for console_line_editor_top: drives console bytes and read requests and
// checks every result against a line predictor held in a small scoreboard class.
// Depends on cle_pkg and console_line_editor_top.
module console_line_editor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cle_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;

	typedef struct packed {
		event_t     ev;
		logic [7:0] out_byte;
		logic [6:0] erase_count;
		logic [6:0] line_length;
	} line_result_t;

	class line_editor_sb;
		logic [7:0]   line_bytes [LINE_MAX_DEF];
		bit           written [LINE_MAX_DEF];
		int unsigned  fill;
		int unsigned  buf_size;
		line_result_t expected_q [$];
		int unsigned  errors;
		int unsigned  n_event [5];
		int unsigned  n_dropped;
		int unsigned  max_fill;

		function new();
			fill = 0;
			buf_size = BUF_SIZE_RST;
			errors = 0;
			n_dropped = 0;
			max_fill = 0;
			foreach (written[i]) written[i] = 1'b0;
			foreach (n_event[i]) n_event[i] = 0;
		endfunction

		function void set_size(logic [7:0] v);
			buf_size = v;
		endfunction

		// bytes kept per line: one slot is reserved for the terminator
		function int unsigned capacity();
			int unsigned lim;
			lim = buf_size;
			if (lim > LINE_MAX_DEF)
				lim = LINE_MAX_DEF;
			return (lim == 0) ? 0 : lim - 1;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_request(logic [0:0] user, logic [15:0] data);
			line_result_t r;
			logic [7:0]   c;
			logic [6:0]   idx;
			c = data[7:0];
			idx = data[14:8];
			r.ev = EV_ECHO;
			r.out_byte = '0;
			r.erase_count = '0;
			r.line_length = '0;
			if (req_t'(user) == REQ_READ) begin
				r.ev = EV_READ;
				r.out_byte = line_bytes[idx];
			end else begin
				case (c)
					CH_LF, CH_CR: begin
						r.ev = EV_DONE;
						r.line_length = fill[6:0];
						fill = 0;
					end
					CH_BS: begin
						r.ev = EV_ERASE;
						r.erase_count = 7'd1;
						if (fill > 0)
							fill--;
					end
					CH_KILL: begin
						r.ev = EV_ERASE;
						r.erase_count = fill[6:0];
						fill = 0;
					end
					CH_SPEC_LO, CH_SPEC_HI: begin
						r.ev = EV_SPECIAL;
						r.out_byte = c;
						r.line_length = 7'd1;
						line_bytes[0] = c;
						written[0] = 1'b1;
						fill = 0;
					end
					default: begin
						r.out_byte = c;
						if (c >= CH_PRINT_LO && c < CH_DEL) begin
							if (fill < capacity()) begin
								line_bytes[fill] = c;
								written[fill] = 1'b1;
								fill++;
								if (fill > max_fill)
									max_fill = fill;
							end else begin
								n_dropped++;
							end
						end
					end
				endcase
			end
			n_event[r.ev]++;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [23:0] data, logic [2:0] user);
			line_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding: event_res %0d, tdata %h", user, data);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (user !== e.ev) begin
				$error("event_res: expected %0d, actual %0d", e.ev, user);
				errors++;
			end
			if (data[7:0] !== e.out_byte) begin
				$error("out_byte: expected %h, actual %h", e.out_byte, data[7:0]);
				errors++;
			end
			if (data[14:8] !== e.erase_count) begin
				$error("erase_count: expected %0d, actual %0d", e.erase_count, data[14:8]);
				errors++;
			end
			if (data[21:15] !== e.line_length) begin
				$error("line_length: expected %0d, actual %0d", e.line_length, data[21:15]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;

	line_editor_sb sb = new();
	bit            calm = 1'b0;
	int unsigned   n_sent = 0;
	int unsigned   n_sizes = 0;
	int unsigned   quiet_cycles = 0;

	console_line_editor_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 15);
	end

	// requests are noted before results so the predictor sees them in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_size(cfg_data);
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					quiet_cycles, sb.pending());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic push_req(req_t kind, logic [7:0] c, logic [6:0] idx);
		if (!calm && $urandom_range(0, 99) < 15) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tuser = kind;
		s_tdata = {1'b0, idx, c};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		n_sent++;
	endtask

	task automatic send_byte(logic [7:0] c);
		push_req(REQ_RX, c, 7'($urandom_range(0, 127)));
	endtask

	task automatic send_read(logic [6:0] idx);
		push_req(REQ_READ, 8'($urandom_range(0, 255)), idx);
	endtask

	// only entries written since reset may be read back
	task automatic send_read_any();
		int unsigned s;
		int unsigned j;
		s = $urandom_range(0, 127);
		for (j = 0; j < 128; j++) begin
			if (sb.written[(s + j) % 128]) begin
				send_read(7'((s + j) % 128));
				return;
			end
		end
	endtask

	task automatic write_size(logic [7:0] v);
		while (sb.pending() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_data = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		n_sizes++;
	endtask

	// mostly whole lines with random text and edits, some stray bytes and reads
	task automatic run_lines(int unsigned quota);
		int unsigned start;
		int unsigned len;
		int unsigned k;
		start = n_sent;
		while (n_sent - start < quota) begin
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(0, sb.capacity() + 3);
				else
					len = $urandom_range(0, 10);
				for (k = 0; k < len; k++) begin
					case ($urandom_range(0, 19))
						0: send_byte(CH_BS);
						1: send_read_any();
						default: send_byte(8'($urandom_range(32, 126)));
					endcase
				end
				k = $urandom_range(0, 19);
				if (k < 13)
					send_byte(k[0] ? CH_CR : CH_LF);
				else if (k < 16)
					send_byte(CH_KILL);
				else
					send_byte(k[0] ? CH_SPEC_HI : CH_SPEC_LO);
				repeat ($urandom_range(0, 2)) send_read_any();
			end else if ($urandom_range(0, 1)) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_read_any();
			end
		end
	endtask

	initial begin
		logic [7:0] sizes [10];
		sizes = '{8'd0, 8'd1, 8'd2, 8'd7, 8'd255, 8'd129, 8'd128, 8'd127, 8'd40, 8'd3};
		sizes[8] = 8'($urandom_range(3, 126));

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty-line edits, printable edges, codes, overflow
		send_byte(CH_BS);
		send_byte(CH_KILL);
		send_byte(CH_CR);
		send_byte(CH_PRINT_LO);
		send_byte(8'h7e);
		send_byte(CH_DEL);
		send_byte(8'h1f);
		send_byte(8'h00);
		send_byte(8'h80);
		send_read(7'd0);
		send_read(7'd1);
		send_byte(CH_BS);
		send_byte("A");
		send_byte(CH_KILL);
		send_byte("x");
		send_byte("y");
		send_byte(CH_LF);
		send_read(7'd1);
		send_byte(CH_SPEC_LO);
		send_read(7'd0);
		send_byte(CH_SPEC_HI);
		send_read(7'd0);
		write_size(8'd2);
		send_byte("a");
		send_byte("b");
		send_byte(CH_CR);

		foreach (sizes[p]) begin
			write_size(sizes[p]);
			calm = (p == 6);
			run_lines(p == 6 ? 200 : 100);
		end
		calm = 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (5) @(posedge clk);

		$display("%0d requests over %0d buffer sizes: %0d echo, %0d erase, %0d line, %0d special, %0d read",
			n_sent, n_sizes, sb.n_event[EV_ECHO], sb.n_event[EV_ERASE], sb.n_event[EV_DONE],
			sb.n_event[EV_SPECIAL], sb.n_event[EV_READ]);
		$display("longest line %0d bytes, %0d printable bytes refused for lack of room",
			sb.max_fill, sb.n_dropped);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
rtl/core/cle_pkg.sv
rtl/core/console_line_editor_top.sv
sim/console_line_editor_top_tb.sv
